// ===== rtl/serial_to_can_frame_parser_assert.svh =====
// assertion macros used by rtl/serial_to_can_frame_parser.sv
`ifndef SERIAL_TO_CAN_FRAME_PARSER_ASSERT_SVH
`define SERIAL_TO_CAN_FRAME_PARSER_ASSERT_SVH

// checked on every rising edge once reset is released
`define S2CFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked during reset as well
`define S2CFP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/s2cfp_pkg.sv =====
`timescale 1ns / 1ps

package s2cfp_pkg;

  localparam logic [7:0] HeaderByte  = 8'hAA;
  localparam logic [7:0] CommandByte = 8'h01;

  localparam int unsigned MaxPayload = 8;
  localparam int unsigned StoreDepth = 8;
  localparam int unsigned StoreIdxW  = $clog2(StoreDepth);

  typedef enum logic [6:0] {
    PhHunt = 7'b0000001,
    PhCmd  = 7'b0000010,
    PhIdh  = 7'b0000100,
    PhIdl  = 7'b0001000,
    PhLen  = 7'b0010000,
    PhData = 7'b0100000,
    PhSum  = 7'b1000000
  } phase_e;

  typedef logic [7:0] byte_t;

endpackage

// ===== rtl/serial_to_can_frame_parser.sv =====
`timescale 1ns / 1ps

// channel | signals                              | direction
// --------+--------------------------------------+----------
// rx      | in_valid_i, in_ready_o, rx_byte_i    | in
// frame   | out_valid_o, out_ready_i, frame_id_o,| out
//         | frame_length_o, data_0_o..data_7_o   |
//
// one serial byte per cycle while in_ready_o is high; each byte updates the parser
// state in the cycle it is taken, and a frame appears in the output register the
// cycle after its checksum byte. reset returns to header hunt with a zeroed payload
// store. only a checksum byte waits when a previous frame is still unclaimed; all
// other bytes are taken while the output register is full.

`include "serial_to_can_frame_parser_assert.svh"

module serial_to_can_frame_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] frame_id_o,
  output logic [3:0]  frame_length_o,
  output logic [7:0]  data_0_o,
  output logic [7:0]  data_1_o,
  output logic [7:0]  data_2_o,
  output logic [7:0]  data_3_o,
  output logic [7:0]  data_4_o,
  output logic [7:0]  data_5_o,
  output logic [7:0]  data_6_o,
  output logic [7:0]  data_7_o
);
  import s2cfp_pkg::*;

  phase_e phase_q, phase_d;
  byte_t  id_high_q, id_high_d;
  byte_t  id_low_q, id_low_d;
  logic [3:0] count_q, count_d;
  logic [3:0] pos_q, pos_d;
  byte_t  xor_q, xor_d;
  byte_t  store_q [StoreDepth];
  logic   store_we;

  logic        out_valid_q;
  logic [15:0] out_id_q;
  logic [3:0]  out_len_q;
  byte_t       out_data_q [StoreDepth];

  logic in_fire;
  logic frame_hit;
  logic out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (phase_q != PhSum) || out_free;
  assign in_fire    = in_valid_i && in_ready_o;
  assign frame_hit  = in_fire && (phase_q == PhSum) && (rx_byte_i == xor_q);

  always_comb begin
    phase_d   = phase_q;
    id_high_d = id_high_q;
    id_low_d  = id_low_q;
    count_d   = count_q;
    pos_d     = pos_q;
    xor_d     = xor_q;
    store_we  = 1'b0;
    if (in_fire) begin
      unique case (phase_q)
        PhCmd: begin
          phase_d = (rx_byte_i == CommandByte) ? PhIdh : PhHunt;
        end
        PhIdh: begin
          id_high_d = rx_byte_i;
          xor_d     = rx_byte_i;
          phase_d   = PhIdl;
        end
        PhIdl: begin
          id_low_d = rx_byte_i;
          xor_d    = xor_q ^ rx_byte_i;
          phase_d  = PhLen;
        end
        PhLen: begin
          if (rx_byte_i > 8'(MaxPayload)) begin
            phase_d = PhHunt;
          end else begin
            count_d = rx_byte_i[3:0];
            pos_d   = 4'd0;
            phase_d = (rx_byte_i == 8'd0) ? PhSum : PhData;
          end
        end
        PhData: begin
          store_we = 1'b1;
          xor_d    = xor_q ^ rx_byte_i;
          pos_d    = pos_q + 4'd1;
          if ((pos_q + 4'd1) >= count_q) begin
            phase_d = PhSum;
          end
        end
        PhSum: begin
          phase_d = PhHunt;
        end
        default: begin
          // hunting, and any code that should not occur
          phase_d = (rx_byte_i == HeaderByte) ? PhCmd : PhHunt;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhHunt;
      id_high_q <= '0;
      id_low_q  <= '0;
      count_q   <= '0;
      pos_q     <= '0;
      xor_q     <= '0;
      for (int i = 0; i < StoreDepth; i++) begin
        store_q[i] <= '0;
      end
    end else begin
      phase_q   <= phase_d;
      id_high_q <= id_high_d;
      id_low_q  <= id_low_d;
      count_q   <= count_d;
      pos_q     <= pos_d;
      xor_q     <= xor_d;
      if (store_we) begin
        store_q[pos_q[StoreIdxW-1:0]] <= rx_byte_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (frame_hit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // frame snapshot, so later payload bytes cannot disturb a waiting frame
  always_ff @(posedge clk_i) begin
    if (frame_hit) begin
      out_id_q  <= {id_high_q, id_low_q};
      out_len_q <= count_q;
      out_data_q <= store_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign frame_id_o     = out_id_q;
  assign frame_length_o = out_len_q;
  assign data_0_o       = out_data_q[0];
  assign data_1_o       = out_data_q[1];
  assign data_2_o       = out_data_q[2];
  assign data_3_o       = out_data_q[3];
  assign data_4_o       = out_data_q[4];
  assign data_5_o       = out_data_q[5];
  assign data_6_o       = out_data_q[6];
  assign data_7_o       = out_data_q[7];

  `S2CFP_ASSERT(a_frame_on_match, frame_hit |=> out_valid_o && frame_id_o == $past({id_high_q, id_low_q}), "matching checksum did not load a frame")
  `S2CFP_ASSERT(a_pos_in_range, (phase_q == PhData) |-> (pos_q < count_q), "payload position beyond length")
  `S2CFP_ASSERT(a_long_aborts, (in_fire && phase_q == PhLen && rx_byte_i > 8'(MaxPayload)) |=> (phase_q == PhHunt), "oversize length did not abort")
  `S2CFP_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> !out_valid_o, "frame valid during reset")

endmodule
